>>> src/trs_pkg.sv
// Shared types, constants and helpers for the world/normal matrix builder.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package trs_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int CORDIC_ITER_DEF = 16;
	localparam int RF              = 29;   // fraction bits of rotation terms
	localparam int ANG_F           = 24;   // fraction bits of CORDIC angles
	localparam int TABLE_LEN       = 24;
	localparam int QDEPTH          = 2;    // job queue between front and back
	localparam int DW              = 80;   // divider datapath width
	localparam int QW              = 32;   // quotient bits per division

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} trs_in_t;

	typedef struct packed {
		logic               which_matrix;
		logic [1:0]         row_index;
		logic signed [31:0] col_0;
		logic signed [31:0] col_1;
		logic signed [31:0] col_2;
		logic signed [31:0] col_3;
		logic               singular;
		logic               last_row;
	} trs_out_t;

	// classified job handed from front to back
	typedef struct packed {
		trs_in_t    item;
		logic [2:0] zero_scale;
	} trs_job_t;

	typedef struct packed {
		logic     valid;
		trs_job_t job;
	} trs_qhead_t;

	// atan(2^-i) in degrees, ANG_F fraction bits
	function automatic logic signed [34:0] step_angle(input logic [4:0] i);
		logic signed [34:0] v;
		case (i)
			5'd0:  v = 35'sd754974720;
			5'd1:  v = 35'sd445687602;
			5'd2:  v = 35'sd235489088;
			5'd3:  v = 35'sd119537938;
			5'd4:  v = 35'sd60000934;
			5'd5:  v = 35'sd30029717;
			5'd6:  v = 35'sd15018523;
			5'd7:  v = 35'sd7509720;
			5'd8:  v = 35'sd3754917;
			5'd9:  v = 35'sd1877466;
			5'd10: v = 35'sd938734;
			5'd11: v = 35'sd469367;
			5'd12: v = 35'sd234684;
			5'd13: v = 35'sd117342;
			5'd14: v = 35'sd58671;
			5'd15: v = 35'sd29335;
			5'd16: v = 35'sd14668;
			5'd17: v = 35'sd7334;
			5'd18: v = 35'sd3667;
			5'd19: v = 35'sd1833;
			5'd20: v = 35'sd917;
			5'd21: v = 35'sd458;
			5'd22: v = 35'sd229;
			5'd23: v = 35'sd115;
			default: v = 35'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh000000007FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sh0000000080000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> src/trs_front.sv
// Front end: takes transfers on the command port, flags zero scales and
// queues jobs for the back end. Depends on trs_pkg.
`timescale 1ns / 1ps

module trs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  trs_pkg::trs_in_t   item,
	output trs_pkg::trs_qhead_t head,
	input  logic               take
);

	localparam int PW = (trs_pkg::QDEPTH > 1) ? $clog2(trs_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(trs_pkg::QDEPTH + 1);

	trs_pkg::trs_job_t q_q [trs_pkg::QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;
	trs_pkg::trs_job_t job_in;

	assign busy = (cnt_q == CW'(trs_pkg::QDEPTH));
	assign push = start && !busy;
	assign pop  = take && (cnt_q != '0);

	always_comb begin
		job_in.item       = item;
		job_in.zero_scale = {item.scale_z == 32'sd0, item.scale_y == 32'sd0,
			item.scale_x == 32'sd0};
	end

	assign head.valid = (cnt_q != '0);
	assign head.job   = q_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_q[wptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(trs_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PW'(trs_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> src/trs_sincos.sv
// Three-lane sine/cosine unit: modulo-360 reduction by restoring steps,
// quadrant fold, then one CORDIC iteration per cycle. Depends on trs_pkg.
`timescale 1ns / 1ps

module trs_sincos #(
	parameter int FRAC_BITS         = trs_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = trs_pkg::CORDIC_ITER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [31:0] ang [3],
	output logic               done,
	output logic signed [31:0] cs [3],
	output logic signed [31:0] sn [3]
);

	localparam int MOD_STEPS = 25 - FRAC_BITS;
	localparam int ITERS = (CORDIC_ITERATIONS < trs_pkg::TABLE_LEN) ?
		CORDIC_ITERATIONS : trs_pkg::TABLE_LEN;
	localparam int CMAX = (MOD_STEPS > ITERS) ? MOD_STEPS : ITERS;
	localparam int CW = $clog2(CMAX + 1);
	localparam logic [63:0] FULL = 64'd360 << FRAC_BITS;
	localparam logic signed [63:0] A90  = 64'sd90 << trs_pkg::ANG_F;
	localparam logic signed [63:0] A180 = 64'sd180 << trs_pkg::ANG_F;
	localparam logic signed [63:0] A360 = 64'sd360 << trs_pkg::ANG_F;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_ROT  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [32:0]         rem_q  [3];
	logic [2:0]          aneg_q;
	logic [2:0]          flip_q;
	logic signed [34:0]  z_q    [3];
	logic signed [32:0]  x_q    [3];
	logic signed [32:0]  y_q    [3];
	logic [5:0]          mod_k;
	logic [63:0]         sub;
	logic signed [63:0]  zf     [3];
	logic [2:0]          fl;
	logic [63:0]         rr     [3];
	logic signed [34:0]  stp;

	assign mod_k = 6'(MOD_STEPS - 1) - 6'(cnt_q);
	assign sub   = FULL << mod_k;
	assign stp   = trs_pkg::step_angle(5'(cnt_q));

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rr[l] = (aneg_q[l] && rem_q[l] != '0) ? FULL - {31'b0, rem_q[l]} :
				{31'b0, rem_q[l]};
			zf[l] = signed'(rr[l] << (trs_pkg::ANG_F - FRAC_BITS));
			fl[l] = 1'b0;
			if (zf[l] >= A180)
				zf[l] = zf[l] - A360;
			if (zf[l] > A90) begin
				zf[l] = zf[l] - A180;
				fl[l] = 1'b1;
			end else if (zf[l] < -A90) begin
				zf[l] = zf[l] + A180;
				fl[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						aneg_q[l] <= ang[l][31];
						rem_q[l]  <= ang[l][31] ? 33'(-{ang[l][31], ang[l]}) :
							{1'b0, ang[l]};
					end
				end
				ST_MOD: begin
					if ({31'b0, rem_q[l]} >= sub)
						rem_q[l] <= rem_q[l] - sub[32:0];
				end
				ST_FOLD: begin
					z_q[l]    <= zf[l][34:0];
					flip_q[l] <= fl[l];
					x_q[l]    <= 33'sd326016437;
					y_q[l]    <= '0;
				end
				ST_ROT: begin
					if (!z_q[l][34]) begin
						x_q[l] <= x_q[l] - (y_q[l] >>> cnt_q);
						y_q[l] <= y_q[l] + (x_q[l] >>> cnt_q);
						z_q[l] <= z_q[l] - stp;
					end else begin
						x_q[l] <= x_q[l] + (y_q[l] >>> cnt_q);
						y_q[l] <= y_q[l] - (x_q[l] >>> cnt_q);
						z_q[l] <= z_q[l] + stp;
					end
				end
				ST_OUT: begin
					cs[l] <= flip_q[l] ? 32'(-x_q[l]) : x_q[l][31:0];
					sn[l] <= flip_q[l] ? 32'(-y_q[l]) : y_q[l][31:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_MOD;
						cnt_q   <= '0;
					end
				end
				ST_MOD: begin
					if (cnt_q == CW'(MOD_STEPS - 1))
						state_q <= ST_FOLD;
					cnt_q <= (cnt_q == CW'(MOD_STEPS - 1)) ? '0 : cnt_q + 1'b1;
				end
				ST_FOLD: begin
					state_q <= ST_ROT;
					cnt_q   <= '0;
				end
				ST_ROT: begin
					if (cnt_q == CW'(ITERS - 1))
						state_q <= ST_OUT;
					cnt_q <= cnt_q + 1'b1;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/trs_back.sv
// Back end: rotation products, world rows, nine-lane serial divider for
// the normal rows, and the row emitter. Depends on trs_pkg and trs_sincos.
`timescale 1ns / 1ps

module trs_back #(
	parameter int FRAC_BITS         = trs_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = trs_pkg::CORDIC_ITER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  trs_pkg::trs_qhead_t head,
	output logic                take,
	output logic                done,
	output trs_pkg::trs_out_t   result
);

	localparam int NSH    = 2 * FRAC_BITS - trs_pkg::RF;
	localparam int NUM_SH = (NSH > 0) ? NSH : 0;
	localparam int DEN_SH = (NSH < 0) ? -NSH : 0;
	localparam int DW     = trs_pkg::DW;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TRIG = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_HAND = 3'd4;

	localparam logic [4:0] OP_T10 = 5'd0;
	localparam logic [4:0] OP_T12 = 5'd1;
	localparam logic [4:0] OP_T20 = 5'd2;
	localparam logic [4:0] OP_T22 = 5'd3;
	localparam logic [4:0] OP_R00 = 5'd4;
	localparam logic [4:0] OP_R01 = 5'd5;
	localparam logic [4:0] OP_R10 = 5'd6;
	localparam logic [4:0] OP_R11 = 5'd7;
	localparam logic [4:0] OP_R20 = 5'd8;
	localparam logic [4:0] OP_R21 = 5'd9;
	localparam logic [4:0] OP_W00 = 5'd10;
	localparam logic [4:0] OP_LAST = 5'd18;

	logic [2:0]          state_q;
	trs_pkg::trs_job_t   job_q;
	logic                sc_go, sc_done;
	logic signed [31:0]  ang [3];
	logic signed [31:0]  cs  [3];
	logic signed [31:0]  sn  [3];

	// product stage
	logic [4:0]          op_q, op_s1;
	logic                mv_s1;
	logic signed [31:0]  a0, b0, a1, b1;
	logic                sub_op, sub_s1;
	logic signed [63:0]  p0_s1, p1_s1, psum, prnd;

	logic signed [31:0]  t10_q, t12_q, t20_q, t22_q;
	logic signed [31:0]  r_q [3][2];
	logic signed [31:0]  rm  [3][3];
	logic signed [31:0]  w_q [3][3];
	logic signed [31:0]  scl [3];

	// divider lanes, index 3*i+j
	logic [DW-1:0]       drem_q [9];
	logic [DW-1:0]       dden_q [9];
	logic [31:0]         dq_q   [9];
	logic [8:0]          dneg_q, dovf_q, dzero_q, drs_q;
	logic [4:0]          dcnt_q;
	logic [DW-1:0]       an [9];
	logic [DW-1:0]       ad [9];
	logic [DW-1:0]       nn [9];
	logic [DW-1:0]       dd [9];
	logic [DW-1:0]       trial [9];
	logic signed [31:0]  nval [9];

	// emitter
	logic [3:0][31:0]    erow_q [8];
	logic                esing_q;
	logic                eact_q;
	logic [2:0]          eidx_q;
	logic [3:0][31:0]    hrow [8];

	assign take  = (state_q == ST_IDLE) && head.valid;
	assign sc_go = take;
	assign ang[0] = head.job.item.angle_x;
	assign ang[1] = head.job.item.angle_y;
	assign ang[2] = head.job.item.angle_z;
	assign scl[0] = job_q.item.scale_x;
	assign scl[1] = job_q.item.scale_y;
	assign scl[2] = job_q.item.scale_z;

	trs_sincos #(
		.FRAC_BITS        (FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_sincos (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (sc_go),
		.ang   (ang),
		.done  (sc_done),
		.cs    (cs),
		.sn    (sn)
	);

	// full rotation matrix; column 2 is -sn[1] and the T12 and T22 products
	always_comb begin
		rm[0][0] = r_q[0][0]; rm[0][1] = r_q[0][1]; rm[0][2] = -sn[1];
		rm[1][0] = r_q[1][0]; rm[1][1] = r_q[1][1]; rm[1][2] = t12_q;
		rm[2][0] = r_q[2][0]; rm[2][1] = r_q[2][1]; rm[2][2] = t22_q;
	end

	always_comb begin
		a0 = '0; b0 = '0; a1 = '0; b1 = '0; sub_op = 1'b0;
		case (op_q)
			OP_T10: begin a0 = sn[0]; b0 = sn[1]; end
			OP_T12: begin a0 = sn[0]; b0 = cs[1]; end
			OP_T20: begin a0 = cs[0]; b0 = sn[1]; end
			OP_T22: begin a0 = cs[0]; b0 = cs[1]; end
			OP_R00: begin a0 = cs[1]; b0 = cs[2]; end
			OP_R01: begin a0 = cs[1]; b0 = sn[2]; end
			OP_R10: begin a0 = t10_q; b0 = cs[2]; a1 = cs[0]; b1 = sn[2]; sub_op = 1'b1; end
			OP_R11: begin a0 = t10_q; b0 = sn[2]; a1 = cs[0]; b1 = cs[2]; end
			OP_R20: begin a0 = t20_q; b0 = cs[2]; a1 = -sn[0]; b1 = sn[2]; sub_op = 1'b1; end
			OP_R21: begin a0 = t20_q; b0 = sn[2]; a1 = -sn[0]; b1 = cs[2]; end
			OP_W00 + 5'd0: begin a0 = scl[0]; b0 = rm[0][0]; end
			OP_W00 + 5'd1: begin a0 = scl[0]; b0 = rm[0][1]; end
			OP_W00 + 5'd2: begin a0 = scl[0]; b0 = rm[0][2]; end
			OP_W00 + 5'd3: begin a0 = scl[1]; b0 = rm[1][0]; end
			OP_W00 + 5'd4: begin a0 = scl[1]; b0 = rm[1][1]; end
			OP_W00 + 5'd5: begin a0 = scl[1]; b0 = rm[1][2]; end
			OP_W00 + 5'd6: begin a0 = scl[2]; b0 = rm[2][0]; end
			OP_W00 + 5'd7: begin a0 = scl[2]; b0 = rm[2][1]; end
			OP_W00 + 5'd8: begin a0 = scl[2]; b0 = rm[2][2]; end
			default: ;
		endcase
	end

	assign psum = sub_s1 ? p0_s1 - p1_s1 : p0_s1 + p1_s1;
	assign prnd = (psum + (64'sd1 <<< (trs_pkg::RF - 1))) >>> trs_pkg::RF;

	always_ff @(posedge clk) begin
		p0_s1  <= a0 * b0;
		p1_s1  <= a1 * b1;
		sub_s1 <= sub_op;
		op_s1  <= op_q;
		if (mv_s1) begin
			case (op_s1)
				OP_T10: t10_q <= prnd[31:0];
				OP_T12: t12_q <= prnd[31:0];
				OP_T20: t20_q <= prnd[31:0];
				OP_T22: t22_q <= prnd[31:0];
				OP_R00: r_q[0][0] <= prnd[31:0];
				OP_R01: r_q[0][1] <= prnd[31:0];
				OP_R10: r_q[1][0] <= prnd[31:0];
				OP_R11: r_q[1][1] <= prnd[31:0];
				OP_R20: r_q[2][0] <= prnd[31:0];
				OP_R21: r_q[2][1] <= prnd[31:0];
				OP_W00 + 5'd0: w_q[0][0] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd1: w_q[0][1] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd2: w_q[0][2] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd3: w_q[1][0] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd4: w_q[1][1] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd5: w_q[1][2] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd6: w_q[2][0] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd7: w_q[2][1] <= trs_pkg::sat32(prnd);
				OP_W00 + 5'd8: w_q[2][2] <= trs_pkg::sat32(prnd);
				default: ;
			endcase
		end
	end

	// divider setup: q = (2|n| + |d|) / (2|d|), n and d aligned to FRAC_BITS
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				an[3*i+j] = rm[i][j][31] ? DW'(-{{(DW-32){rm[i][j][31]}}, rm[i][j]}) :
					DW'(rm[i][j]);
				ad[3*i+j] = scl[j][31] ? DW'(-{{(DW-32){scl[j][31]}}, scl[j]}) :
					DW'(scl[j]);
				nn[3*i+j] = ((an[3*i+j] << NUM_SH) << 1) + (ad[3*i+j] << DEN_SH);
				dd[3*i+j] = (ad[3*i+j] << DEN_SH) << 1;
			end
		end
		for (int k = 0; k < 9; k++) begin
			trial[k] = dden_q[k] << dcnt_q;
			if (dzero_q[k])
				nval[k] = drs_q[k] ? 32'sh80000000 : 32'sh7FFFFFFF;
			else if (dovf_q[k])
				nval[k] = dneg_q[k] ? 32'sh80000000 : 32'sh7FFFFFFF;
			else if (dneg_q[k])
				nval[k] = (dq_q[k] > 32'h80000000) ? 32'sh80000000 : -dq_q[k];
			else
				nval[k] = (dq_q[k] > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : dq_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			if (state_q == ST_MUL && op_q == OP_LAST) begin
				drem_q[k]  <= nn[k];
				dden_q[k]  <= dd[k];
				dq_q[k]    <= '0;
				dzero_q[k] <= (dd[k] == '0);
				dovf_q[k]  <= (nn[k] >= (dd[k] << trs_pkg::QW));
				dneg_q[k]  <= rm[k/3][k%3][31] != scl[k%3][31];
				drs_q[k]   <= rm[k/3][k%3][31];
			end else if (state_q == ST_DIV) begin
				if (drem_q[k] >= trial[k]) begin
					drem_q[k]         <= drem_q[k] - trial[k];
					dq_q[k][dcnt_q]   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_q <= head.job;
	end

	// rows as they leave, assembled when the job is handed to the emitter
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hrow[i]     = {32'd0, w_q[i][2], w_q[i][1], w_q[i][0]};
			hrow[4 + i] = {32'd0, nval[3*i+2], nval[3*i+1], nval[3*i]};
		end
		hrow[3] = {ONE, job_q.item.pos_z, job_q.item.pos_y, job_q.item.pos_x};
		hrow[7] = {ONE, 32'd0, 32'd0, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HAND && !eact_q) begin
			erow_q  <= hrow;
			esing_q <= |job_q.zero_scale;
		end
		result.which_matrix <= eidx_q[2];
		result.row_index    <= eidx_q[1:0];
		result.col_0        <= erow_q[eidx_q][0];
		result.col_1        <= erow_q[eidx_q][1];
		result.col_2        <= erow_q[eidx_q][2];
		result.col_3        <= erow_q[eidx_q][3];
		result.singular     <= esing_q;
		result.last_row     <= (eidx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= '0;
			mv_s1   <= 1'b0;
			dcnt_q  <= '0;
			eact_q  <= 1'b0;
			eidx_q  <= '0;
			done    <= 1'b0;
		end else begin
			mv_s1 <= (state_q == ST_MUL);
			done  <= eact_q;
			if (eact_q) begin
				eidx_q <= eidx_q + 1'b1;
				if (eidx_q == 3'd7)
					eact_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take)
						state_q <= ST_TRIG;
				end
				ST_TRIG: begin
					if (sc_done) begin
						state_q <= ST_MUL;
						op_q    <= '0;
					end
				end
				ST_MUL: begin
					op_q <= op_q + 1'b1;
					if (op_q == OP_LAST) begin
						state_q <= ST_DIV;
						dcnt_q  <= 5'(trs_pkg::QW - 1);
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0)
						state_q <= ST_HAND;
				end
				ST_HAND: begin
					if (!eact_q) begin
						eact_q  <= 1'b1;
						eidx_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/trs_world_and_normal_matrix.sv
// A transfer passes the job queue, the sine/cosine unit, the product pipe
// and the serial divider before its first result row; the eight rows then
// follow back to back, one row per cycle.
// The CORDIC loop and the 32-step serial divider set the item rate. The back
// end takes the next item once the prior rows go to the emitter. The result
// side cannot stall. arst_n clears the queue, sequencers and emitter at once.
// Top level of the world/normal matrix builder. Depends on trs_pkg,
// trs_front and trs_back.
`timescale 1ns / 1ps

module trs_world_and_normal_matrix #(
	parameter int FRAC_BITS         = trs_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = trs_pkg::CORDIC_ITER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  trs_pkg::trs_in_t  item,
	output logic              done,
	output trs_pkg::trs_out_t result
);

	// Front: a transfer lands in a two-entry job queue, tagged with its
	// zero-scale flags, so the back end can be mid-item while the next one
	// waits. busy is simply "queue full".
	trs_pkg::trs_qhead_t head;
	logic                take;

	trs_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.head  (head),
		.take  (take)
	);

	// Back: sine/cosine per axis, shared product pipe for R = Rx*Ry*Rz and
	// the world rows, nine divider lanes for the normal rows. Finished rows
	// are copied into an emit buffer so the next job starts while the
	// previous eight rows stream out under the done strobe.
	trs_back #(
		.FRAC_BITS        (FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.take  (take),
		.done  (done),
		.result(result)
	);

endmodule
